### rtl/core/srgb8_to_cielab16_converter_core_assert.svh
// Assertion macros used by the converter queue; empty when synthesising.
`ifndef SRGB8_TO_CIELAB16_CONVERTER_CORE_ASSERT_SVH
`define SRGB8_TO_CIELAB16_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define S2L_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("converter assertion failed");
// When the first condition holds, the second holds in the next cycle.
`define S2L_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("converter assertion failed");
`else
`define S2L_ASSERT_HOLDS(lbl, expr)
`define S2L_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/s2l_pkg.sv
// Types, constants and constant tables of the sRGB to CIELAB converter.
`default_nettype none
package s2l_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int CUBE_TABLE_LOG2 = 10;
  localparam int SHIFT           = FRAC_BITS - CUBE_TABLE_LOG2;
  localparam int FRAC_W          = (SHIFT > 0) ? SHIFT : 1;
  localparam int KNOT_COUNT      = (1 << CUBE_TABLE_LOG2) + 1;
  localparam int KNOT_W          = CUBE_TABLE_LOG2 + 1;
  localparam int FX_W            = FRAC_BITS + 1;
  localparam int CBRT_SHIFT      = 3 * FRAC_BITS + 3 - CUBE_TABLE_LOG2;

  localparam logic [63:0] FX_ONE   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SPAN     = 64'd1 << CUBE_TABLE_LOG2;
  localparam logic [63:0] KNOT_DEN = 64'd3132 * SPAN;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // White point of D65, in units of 1e-6.
  localparam logic [63:0] WX = 64'd950489;
  localparam logic [63:0] WY = 64'd1000000;
  localparam logic [63:0] WZ = 64'd1088840;

  // sRGB to XYZ matrix, each row divided by its white component.
  localparam logic [FX_W-1:0] COEF [3][3] = '{
    '{FX_W'((64'd4124564 * FX_ONE + 64'd5 * WX) / (64'd10 * WX)),
      FX_W'((64'd3575761 * FX_ONE + 64'd5 * WX) / (64'd10 * WX)),
      FX_W'((64'd1804375 * FX_ONE + 64'd5 * WX) / (64'd10 * WX))},
    '{FX_W'((64'd2126729 * FX_ONE + 64'd5 * WY) / (64'd10 * WY)),
      FX_W'((64'd7151522 * FX_ONE + 64'd5 * WY) / (64'd10 * WY)),
      FX_W'((64'd721750 * FX_ONE + 64'd5 * WY) / (64'd10 * WY))},
    '{FX_W'((64'd193339 * FX_ONE + 64'd5 * WZ) / (64'd10 * WZ)),
      FX_W'((64'd1191920 * FX_ONE + 64'd5 * WZ) / (64'd10 * WZ)),
      FX_W'((64'd9503041 * FX_ONE + 64'd5 * WZ) / (64'd10 * WZ))}
  };

  // Output scaling.
  localparam int M_W     = FRAC_BITS + 8;
  localparam int LN_W    = FRAC_BITS + 24;
  localparam int Q_W     = 23;
  localparam int RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP = 24'd10737419;
  localparam int QR_W    = Q_W + 24;
  localparam logic [63:0] L_OFFSET = 64'd16 * FX_ONE;
  localparam logic [63:0] L_ROUND  = 64'd50 * FX_ONE;
  localparam int DW      = FX_W + 1;
  localparam int AB_W    = FRAC_BITS + 22;
  localparam int SCALE_A = 500 * 257;
  localparam int SCALE_B = 200 * 257;
  localparam logic [63:0] AB_OFFSET = 64'd32896 * FX_ONE;
  localparam logic [63:0] AB_HALF   = FX_ONE >> 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0] lightness_code;
    logic [15:0] a_code;
    logic [15:0] b_code;
  } lab_t;

  typedef struct packed {
    logic [FX_W-1:0] lin_red;
    logic [FX_W-1:0] lin_green;
    logic [FX_W-1:0] lin_blue;
  } lin_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef logic [FX_W-1:0] lin_tab_t [256];
  typedef logic [FX_W-1:0] knot_tab_t [KNOT_COUNT];

  // Linearised value of one gamma-encoded code.
  function automatic logic [FX_W-1:0] lin_entry(input int unsigned v);
    logic [127:0] vv, x, x2, r, cand, r2, r4, p5, y;
    vv = 128'(v);
    r  = '0;
    if (vv * 100000 <= 1031475) begin
      return FX_W'((vv * 100 * FX_ONE + 164730) / 329460);
    end
    if (vv >= 255) begin
      return FX_W'(FX_ONE);
    end
    x  = ((vv * 1000 + 14025) << 32) / 269025;
    x2 = (x * x) >> 32;
    for (int bt = 31; bt >= 0; bt--) begin
      cand = r | (128'd1 << bt);
      r2   = (cand * cand) >> 32;
      r4   = (r2 * r2) >> 32;
      p5   = (r4 * cand) >> 32;
      if (p5 <= x2) begin
        r = cand;
      end
    end
    y = (x2 * r) >> 32;
    return FX_W'((y + (128'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  endfunction

  // Knot of the CIELAB f function.
  function automatic logic [FX_W-1:0] knot_entry(input int unsigned i);
    logic [127:0] ii, x, c, cand;
    ii = 128'(i);
    c  = '0;
    if (ii * 24389 <= 128'(SPAN) * 216) begin
      return FX_W'(((ii * 24389 + 128'(SPAN) * 432) * FX_ONE + 128'(SPAN) * 1566)
                   / KNOT_DEN);
    end
    x = ii << CBRT_SHIFT;
    for (int bt = FRAC_BITS + 1; bt >= 0; bt--) begin
      cand = c | (128'd1 << bt);
      if (cand * cand * cand <= x) begin
        c = cand;
      end
    end
    return FX_W'((c + 1) >> 1);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int unsigned v = 0; v < 256; v++) begin
      tab[v] = lin_entry(v);
    end
    return tab;
  endfunction

  function automatic knot_tab_t build_knot_tab();
    knot_tab_t tab;
    for (int unsigned i = 0; i < KNOT_COUNT; i++) begin
      tab[i] = knot_entry(i);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage
`default_nettype wire

### rtl/core/s2l_front.sv
// Front end: takes pixel transfers and linearises each channel.
`default_nettype none
module s2l_front (
  input  logic             push,
  output logic             full,
  input  s2l_pkg::pixel_t  pixel,
  input  s2l_pkg::q_stat_t qstat,
  output logic             wr,
  output s2l_pkg::lin_t    wdata
);

  // A transfer is taken whenever the queue has room.
  assign full = qstat.full;
  assign wr   = push && !qstat.full;

  // Gamma decoding through the constant table.
  assign wdata.lin_red   = s2l_pkg::LIN_TAB[pixel.red];
  assign wdata.lin_green = s2l_pkg::LIN_TAB[pixel.green];
  assign wdata.lin_blue  = s2l_pkg::LIN_TAB[pixel.blue];

endmodule
`default_nettype wire

### rtl/core/s2l_queue.sv
// Short queue of linearised pixels between front and back.
`default_nettype none
`include "srgb8_to_cielab16_converter_core_assert.svh"
module s2l_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  s2l_pkg::lin_t    wdata,
  input  logic             rd,
  output s2l_pkg::lin_t    rdata,
  output s2l_pkg::q_stat_t qstat
);

  s2l_pkg::lin_t                   slots [s2l_pkg::QUEUE_DEPTH];
  logic [s2l_pkg::QPTR_W-1:0]      wr_ptr;
  logic [s2l_pkg::QPTR_W-1:0]      rd_ptr;
  logic [s2l_pkg::QCNT_W-1:0]      cnt;

  localparam logic [s2l_pkg::QPTR_W-1:0] LAST = s2l_pkg::QPTR_W'(s2l_pkg::QUEUE_DEPTH - 1);
  localparam logic [s2l_pkg::QCNT_W-1:0] CNT_MAX = s2l_pkg::QCNT_W'(s2l_pkg::QUEUE_DEPTH);

  // Storage: one slot written per transfer.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign rdata       = slots[rd_ptr];
  assign qstat.empty = (cnt == '0);
  assign qstat.full  = (cnt == CNT_MAX);

  // Checks on the queue bookkeeping.
  `S2L_ASSERT_HOLDS(a_cnt_bound, cnt <= CNT_MAX)
  `S2L_ASSERT_HOLDS(a_no_overflow, !(wr && cnt == CNT_MAX))
  `S2L_ASSERT_HOLDS(a_no_underflow, !(rd && cnt == '0))
  `S2L_ASSERT_NEXT(a_fill, wr && !rd, cnt == $past(cnt) + 1'b1)
  `S2L_ASSERT_HOLDS(a_ptr_gap, s2l_pkg::QPTR_W'(wr_ptr - rd_ptr) == cnt[s2l_pkg::QPTR_W-1:0])

endmodule
`default_nettype wire

### rtl/core/s2l_knot_rom.sv
// Two-port registered ROM holding the knots of the CIELAB f function.
`default_nettype none
module s2l_knot_rom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [s2l_pkg::KNOT_W-1:0]   addr_lo,
  input  logic [s2l_pkg::KNOT_W-1:0]   addr_hi,
  output logic [s2l_pkg::FX_W-1:0]     data_lo,
  output logic [s2l_pkg::FX_W-1:0]     data_hi
);

  localparam s2l_pkg::knot_tab_t KNOTS = s2l_pkg::build_knot_tab();

  // Both reads are registered and follow the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      data_lo <= KNOTS[addr_lo];
      data_hi <= KNOTS[addr_hi];
    end
  end

endmodule
`default_nettype wire

### rtl/core/s2l_back.sv
// Back end: matrix, f function, scaling and the output register.
`default_nettype none
module s2l_back (
  input  logic             clk,
  input  logic             rst,
  input  s2l_pkg::lin_t    head,
  input  s2l_pkg::q_stat_t qstat,
  output logic             head_take,
  output s2l_pkg::lab_t    result,
  output logic             empty,
  input  logic             pop
);

  localparam int FXW = s2l_pkg::FX_W;
  localparam int PW  = 2 * FXW;
  localparam int IW  = FXW + s2l_pkg::SHIFT + 3;
  localparam int KW  = s2l_pkg::KNOT_W;
  localparam logic [IW-1:0] IHALF =
    (s2l_pkg::SHIFT > 0) ? IW'(64'd1 << (s2l_pkg::SHIFT - 1)) : '0;
  localparam logic [KW-1:0] KLAST = KW'(s2l_pkg::KNOT_COUNT - 1);

  logic en;
  logic out_vld;
  logic v1, v2, v3, v4, v5, v6, v7;

  logic [FXW-1:0]                 lin_in [3];
  logic [PW-1:0]                  prod [3][3];
  logic [PW+1:0]                  acc [3];
  logic [PW+1-s2l_pkg::FRAC_BITS:0] rnd [3];
  logic [FXW-1:0]                 t [3];
  logic [KW-1:0]                  k [3];
  logic [KW-1:0]                  k1 [3];
  logic [FXW-1:0]                 tk [3];
  logic [FXW-1:0]                 tk1 [3];
  logic [s2l_pkg::FRAC_W-1:0]     frac [3];
  logic signed [IW-1:0]           base [3];
  logic signed [IW-1:0]           dprod [3];
  logic signed [IW-1:0]           isum [3];
  logic signed [FXW:0]            diff [3];
  logic [FXW-1:0]                 f [3];
  logic signed [s2l_pkg::M_W-1:0] m;
  logic signed [s2l_pkg::DW-1:0]  da, db;
  logic [s2l_pkg::LN_W-1:0]       lnum;
  logic [s2l_pkg::Q_W-1:0]        q;
  logic                           qz6, qz7;
  logic signed [s2l_pkg::AB_W-1:0] va, vb;
  logic [s2l_pkg::QR_W-1:0]       qr;
  logic [15:0]                    a7, b7;

  // Signed a or b sum to a saturated code.
  function automatic logic [15:0] ab_code(input logic signed [s2l_pkg::AB_W-1:0] v);
    logic [s2l_pkg::AB_W-1:0] r;
    r = (s2l_pkg::AB_W'(v) + s2l_pkg::AB_W'(s2l_pkg::AB_HALF)) >> s2l_pkg::FRAC_BITS;
    if (v[s2l_pkg::AB_W-1] || v == '0) begin
      return 16'h0000;
    end else if (r > s2l_pkg::AB_W'(16'hffff)) begin
      return 16'hffff;
    end
    return r[15:0];
  endfunction

  // The whole back pipeline moves unless a result waits unclaimed.
  assign en        = !out_vld || pop;
  assign head_take = en && !qstat.empty;
  assign empty     = !out_vld;

  assign lin_in[0] = head.lin_red;
  assign lin_in[1] = head.lin_green;
  assign lin_in[2] = head.lin_blue;

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      v1 <= !qstat.empty;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      out_vld <= v7;
    end
  end

  // Stage 1: the nine matrix products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PW'(s2l_pkg::COEF[i][j]) * PW'(lin_in[j]);
        end
      end
    end
  end

  // Stage 2: row sums, rounded and saturated to one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (PW+2)'(prod[i][0]) + (PW+2)'(prod[i][1]) + (PW+2)'(prod[i][2])
             + (PW+2)'(s2l_pkg::AB_HALF);
      rnd[i] = acc[i][PW+1:s2l_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t[i] <= (rnd[i] > (PW+2-s2l_pkg::FRAC_BITS)'(s2l_pkg::FX_ONE))
              ? FXW'(s2l_pkg::FX_ONE) : rnd[i][FXW-1:0];
      end
    end
  end

  // Stage 3: knot reads around each value.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k[i]  = t[i][s2l_pkg::FRAC_BITS:s2l_pkg::SHIFT];
      k1[i] = (k[i] == KLAST) ? k[i] : k[i] + 1'b1;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_rom
    s2l_knot_rom u_rom (
      .clk     (clk),
      .en      (en),
      .addr_lo (k[ch]),
      .addr_hi (k1[ch]),
      .data_lo (tk[ch]),
      .data_hi (tk1[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        frac[i] <= (s2l_pkg::SHIFT > 0) ? t[i][s2l_pkg::FRAC_W-1:0] : '0;
      end
    end
  end

  // Stage 4: linear interpolation between the knots.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = $signed({1'b0, tk1[i]}) - $signed({1'b0, tk[i]});
      base[i]  = $signed(IW'(tk[i]) << s2l_pkg::SHIFT);
      dprod[i] = IW'(diff[i]) * $signed(IW'(frac[i]));
      isum[i]  = base[i] + dprod[i] + $signed(IHALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f[i] <= isum[i][s2l_pkg::SHIFT +: FXW];
      end
    end
  end

  // Stage 5: lightness term and colour differences.
  always_ff @(posedge clk) begin
    if (en) begin
      m  <= s2l_pkg::M_W'(f[1]) * s2l_pkg::M_W'(116) - s2l_pkg::M_W'(s2l_pkg::L_OFFSET);
      da <= s2l_pkg::DW'(f[0]) - s2l_pkg::DW'(f[1]);
      db <= s2l_pkg::DW'(f[1]) - s2l_pkg::DW'(f[2]);
    end
  end

  // Stage 6: scale lightness by 65535 and the differences by their factors.
  assign lnum = (s2l_pkg::LN_W'(m) << 16) - s2l_pkg::LN_W'(m)
              + s2l_pkg::LN_W'(s2l_pkg::L_ROUND);

  always_ff @(posedge clk) begin
    if (en) begin
      qz6 <= m[s2l_pkg::M_W-1] || (m == '0);
      q   <= lnum[s2l_pkg::FRAC_BITS +: s2l_pkg::Q_W];
      va  <= s2l_pkg::AB_W'(da) * s2l_pkg::AB_W'(s2l_pkg::SCALE_A)
           + s2l_pkg::AB_W'(s2l_pkg::AB_OFFSET);
      vb  <= s2l_pkg::AB_W'(db) * s2l_pkg::AB_W'(s2l_pkg::SCALE_B)
           + s2l_pkg::AB_W'(s2l_pkg::AB_OFFSET);
    end
  end

  // Stage 7: divide lightness by 100 through the reciprocal; finish a and b.
  always_ff @(posedge clk) begin
    if (en) begin
      qr  <= s2l_pkg::QR_W'(q) * s2l_pkg::QR_W'(s2l_pkg::RECIP);
      qz7 <= qz6;
      a7  <= ab_code(va);
      b7  <= ab_code(vb);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (qz7) begin
        result.lightness_code <= 16'h0000;
      end else if (qr[s2l_pkg::QR_W-1:s2l_pkg::RECIP_SHIFT]
                   > (s2l_pkg::QR_W-s2l_pkg::RECIP_SHIFT)'(16'hffff)) begin
        result.lightness_code <= 16'hffff;
      end else begin
        result.lightness_code <= qr[s2l_pkg::RECIP_SHIFT +: 16];
      end
      result.a_code <= a7;
      result.b_code <= b7;
    end
  end

endmodule
`default_nettype wire

### rtl/core/srgb8_to_cielab16_converter_core.sv
// Top level of the sRGB (8 bit) to CIELAB D65 (16 bit code) converter.
//
//   channel   direction  handshake      payload
//   pixel     in         push / full    red, green, blue
//   result    out        pop / empty    lightness_code, a_code, b_code
//
// One pixel is taken per clock while the queue has room; the back pipeline runs at one pixel
// per cycle while no result waits for pop. A pixel passes the queue, the back stages and the output register.
// Reset clears only the queue counters and the stage valid bits; tables are constant.
// While a result waits for pop the back pipeline holds, and the four-entry
// queue keeps taking pixels until it fills.
`default_nettype none
module srgb8_to_cielab16_converter_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  s2l_pkg::pixel_t pixel,
  output logic            empty,
  input  logic            pop,
  output s2l_pkg::lab_t   result
);

  s2l_pkg::q_stat_t qstat;
  s2l_pkg::lin_t    wdata;
  s2l_pkg::lin_t    head;
  logic             wr;
  logic             head_take;

  s2l_front u_front (
    .push  (push),
    .full  (full),
    .pixel (pixel),
    .qstat (qstat),
    .wr    (wr),
    .wdata (wdata)
  );

  s2l_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .wdata (wdata),
    .rd    (head_take),
    .rdata (head),
    .qstat (qstat)
  );

  s2l_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .head_take (head_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

### tb/sv/srgb8_to_cielab16_converter_core_tb.sv
// Self-checking testbench of the sRGB to CIELAB converter core.
`default_nettype none
module srgb8_to_cielab16_converter_core_tb;

  localparam int LIN_F   = s2l_pkg::FRAC_BITS;
  localparam int KNOT_L  = s2l_pkg::CUBE_TABLE_LOG2;
  localparam int KNOTS   = (1 << KNOT_L) + 1;
  localparam int RANDOM_PIXELS = 500;
  localparam int LONG_HOLD = 40;

  logic            clk;
  logic            rst;
  logic            push;
  logic            full;
  s2l_pkg::pixel_t pixel;
  logic            empty;
  logic            pop;
  s2l_pkg::lab_t   result;

  srgb8_to_cielab16_converter_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .result(result)
  );

  // Predictor tables, built from first principles at the start of the run.
  longint unsigned gamma_lut [256];
  longint unsigned cube_lut [KNOTS];
  longint unsigned xyz_coef [3][3];
  s2l_pkg::lab_t   lab_queue [$];
  int     errors;
  bit     feeding_done;
  bit     hold_drain;

  // Directed stimulus: pixel and, where obvious, the expected colour.
  typedef struct packed {
    s2l_pkg::pixel_t pix;
    logic            known;
    s2l_pkg::lab_t   lab;
  } pixel_row_t;

  pixel_row_t directed [16] = '{
    '{'{8'h00, 8'h00, 8'h00}, 1'b1, '{16'd0, 16'd32896, 16'd32896}},
    '{'{8'hff, 8'hff, 8'hff}, 1'b0, '0},
    '{'{8'hff, 8'h00, 8'h00}, 1'b0, '0},
    '{'{8'h00, 8'hff, 8'h00}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'hff}, 1'b0, '0},
    '{'{8'hff, 8'h00, 8'hff}, 1'b0, '0},
    '{'{8'h00, 8'hff, 8'hff}, 1'b0, '0},
    '{'{8'hff, 8'hff, 8'h00}, 1'b0, '0},
    '{'{8'h0a, 8'h0a, 8'h0a}, 1'b0, '0},
    '{'{8'h0b, 8'h0b, 8'h0b}, 1'b0, '0},
    '{'{8'h01, 8'h01, 8'h01}, 1'b0, '0},
    '{'{8'hfe, 8'hfe, 8'hfe}, 1'b0, '0},
    '{'{8'h80, 8'h80, 8'h80}, 1'b0, '0},
    '{'{8'h55, 8'haa, 8'h55}, 1'b0, '0},
    '{'{8'haa, 8'h55, 8'haa}, 1'b0, '0},
    '{'{8'h14, 8'h06, 8'hf0}, 1'b0, '0}
  };

  function automatic longint unsigned gamma_entry(input longint unsigned v);
    logic [127:0] x, x2, r, cand, r2, r4, p5, y;
    if (v * 100000 <= 1031475) begin
      return (100 * v * (64'd1 << LIN_F) + 164730) / 329460;
    end
    if (v >= 255) begin
      return 64'd1 << LIN_F;
    end
    r  = '0;
    x  = ((128'(v) * 1000 + 14025) << 32) / 269025;
    x2 = (x * x) >> 32;
    for (int bt = 31; bt >= 0; bt--) begin
      cand = r | (128'd1 << bt);
      r2 = (cand * cand) >> 32;
      r4 = (r2 * r2) >> 32;
      p5 = (r4 * cand) >> 32;
      if (p5 <= x2) begin
        r = cand;
      end
    end
    y = (x2 * r) >> 32;
    return longint'((y + (128'd1 << (31 - LIN_F))) >> (32 - LIN_F));
  endfunction

  function automatic longint unsigned cube_entry(input longint unsigned i);
    logic [127:0] x, c, cand, sp;
    sp = 128'd1 << KNOT_L;
    if (128'(i) * 24389 <= 216 * sp) begin
      return longint'(((128'(i) * 24389 + 432 * sp) * (128'd1 << LIN_F) + 1566 * sp)
                      / (3132 * sp));
    end
    c = '0;
    x = 128'(i) << (3 * LIN_F + 3 - KNOT_L);
    for (int bt = LIN_F + 1; bt >= 0; bt--) begin
      cand = c | (128'd1 << bt);
      if (cand * cand * cand <= x) begin
        c = cand;
      end
    end
    return longint'((c + 1) >> 1);
  endfunction

  // Table of CIELAB f at a normalised coordinate, with interpolation.
  function automatic longint f_lookup(input longint unsigned t);
    longint unsigned k, frac;
    longint acc;
    k = t >> (LIN_F - KNOT_L);
    if (k >= KNOTS - 1) begin
      return longint'(cube_lut[KNOTS - 1]);
    end
    frac = t & ((64'd1 << (LIN_F - KNOT_L)) - 1);
    acc = longint'(cube_lut[k] << (LIN_F - KNOT_L))
          + (longint'(cube_lut[k + 1]) - longint'(cube_lut[k])) * longint'(frac);
    return (acc + (64'sd1 << (LIN_F - KNOT_L - 1))) >>> (LIN_F - KNOT_L);
  endfunction

  function automatic logic [15:0] opponent_code(input longint fa, input longint fb,
                                                input longint scale);
    longint v;
    longint unsigned q;
    v = scale * 257 * (fa - fb) + 128 * 257 * (64'sd1 << LIN_F);
    if (v <= 0) begin
      return 16'd0;
    end
    q = (longint'(v) + (64'd1 << (LIN_F - 1))) >> LIN_F;
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  // Colour conversion of one pixel.
  function automatic s2l_pkg::lab_t convert_pixel(input s2l_pkg::pixel_t p);
    longint unsigned lin [3];
    longint f [3];
    longint unsigned acc, t, q;
    longint lv;
    s2l_pkg::lab_t o;
    lin[0] = gamma_lut[p.red];
    lin[1] = gamma_lut[p.green];
    lin[2] = gamma_lut[p.blue];
    for (int i = 0; i < 3; i++) begin
      acc = xyz_coef[i][0] * lin[0] + xyz_coef[i][1] * lin[1] + xyz_coef[i][2] * lin[2];
      t = (acc + (64'd1 << (LIN_F - 1))) >> LIN_F;
      if (t > (64'd1 << LIN_F)) begin
        t = 64'd1 << LIN_F;
      end
      f[i] = f_lookup(t);
    end
    lv = (116 * f[1] - 16 * (64'sd1 << LIN_F)) * 65535;
    if (lv <= 0) begin
      o.lightness_code = 16'd0;
    end else begin
      q = (longint'(lv) + 50 * (64'd1 << LIN_F)) / (100 * (64'd1 << LIN_F));
      o.lightness_code = (q > 65535) ? 16'hffff : q[15:0];
    end
    o.a_code = opponent_code(f[0], f[1], 500);
    o.b_code = opponent_code(f[1], f[2], 200);
    return o;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one pixel after the given idle cycles and wait for its transfer.
  task automatic send_pixel(input s2l_pkg::pixel_t p, input int idle);
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
    lab_queue.push_back(convert_pixel(p));
  endtask

  // Sender.
  initial begin
    longint unsigned white [3];
    s2l_pkg::pixel_t p;
    white = '{950489, 1000000, 1088840};
    xyz_coef = '{'{4124564, 3575761, 1804375}, '{2126729, 7151522, 721750},
                 '{193339, 1191920, 9503041}};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        xyz_coef[i][j] = (xyz_coef[i][j] * (64'd1 << LIN_F) + 5 * white[i])
                         / (10 * white[i]);
      end
    end
    for (int v = 0; v < 256; v++) begin
      gamma_lut[v] = gamma_entry(v);
    end
    for (int i = 0; i < KNOTS; i++) begin
      cube_lut[i] = cube_entry(i);
    end
    errors = 0;
    feeding_done = 1'b0;
    hold_drain = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pixel = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[n]) begin
      send_pixel(directed[n].pix, $urandom_range(0, 3));
      if (directed[n].known && lab_queue[$] != directed[n].lab) begin
        $display("%0t predictor disagrees on directed row %0d: expected %h, got %h",
                 $time, n, directed[n].lab, lab_queue[$]);
        errors++;
      end
    end
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == 100) begin
        hold_drain = 1'b1;
      end
      p = s2l_pkg::pixel_t'(24'($urandom()));
      if ($urandom_range(0, 7) == 0) begin
        p.red = {8{p.red[0]}};
      end
      // Keep offering without gaps while the receiver holds off.
      if (n >= 100 && n < 100 + LONG_HOLD) begin
        send_pixel(p, 0);
      end else begin
        send_pixel(p, $urandom_range(0, 3));
      end
    end
    push <= 1'b0;
    feeding_done = 1'b1;
  end

  // Receiver: random idle cycles per transfer, and one long hold-off.
  initial begin
    int idle;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      idle = $urandom_range(0, 3);
      if (hold_drain) begin
        hold_drain = 1'b0;
        idle = LONG_HOLD;
      end
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Compare each result transfer with the oldest expected colour.
  always @(posedge clk) begin
    s2l_pkg::lab_t want;
    if (!rst && pop && !empty) begin
      if (lab_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        errors++;
      end else begin
        want = lab_queue.pop_front();
        if (result.lightness_code !== want.lightness_code)
          $display("%0t lightness_code: expected %0d, got %0d", $time,
                   want.lightness_code, result.lightness_code);
        if (result.a_code !== want.a_code)
          $display("%0t a_code: expected %0d, got %0d", $time, want.a_code, result.a_code);
        if (result.b_code !== want.b_code)
          $display("%0t b_code: expected %0d, got %0d", $time, want.b_code, result.b_code);
        if (result !== want) begin
          errors++;
        end
      end
    end
  end

  // End of run.
  initial begin
    @(posedge feeding_done);
    while (lab_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && lab_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/s2l_pkg.sv
rtl/core/s2l_front.sv
rtl/core/s2l_queue.sv
rtl/core/s2l_knot_rom.sv
rtl/core/s2l_back.sv
rtl/core/srgb8_to_cielab16_converter_core.sv
tb/sv/srgb8_to_cielab16_converter_core_tb.sv
